FILE: rtl/dnf_pkg.sv
// shared types and constants of the directional neighbor finder
// no dependencies; used by every rtl file of the block but dnf_checker
`default_nettype none

package dnf_pkg;

   localparam int IDX_W     = 4;
   localparam int NUM_DIRS  = 4;
   localparam int DIR_UP    = 0;
   localparam int DIR_DOWN  = 1;
   localparam int DIR_LEFT  = 2;
   localparam int DIR_RIGHT = 3;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
   } rect_type;

   typedef struct packed {
      rect_type rect;
      logic     store;
      logic     last;
   } item_type;

   typedef struct packed {
      logic [IDX_W-1:0] elem_index;
      logic             has_up;
      logic [IDX_W-1:0] up_index;
      logic             has_down;
      logic [IDX_W-1:0] down_index;
      logic             has_left;
      logic [IDX_W-1:0] left_index;
      logic             has_right;
      logic [IDX_W-1:0] right_index;
      logic             run_end;
   } result_type;

   typedef enum logic [1:0] {
      BK_LOAD,
      BK_SCAN,
      BK_FLUSH,
      BK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/dnf_front.sv
// front end: accepts requests and marks each as stored or dropped by capacity
// depends on dnf_pkg
`default_nettype none

module dnf_front #(
   parameter int MAX_RECTS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire dnf_pkg::rect_type  req_rect,
   input  wire logic               req_last,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output dnf_pkg::item_type       push_item
);

   localparam int CW = $clog2(MAX_RECTS + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          store;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign store      = (count_ff < CW'(MAX_RECTS));

   always_comb begin
      push_item.rect  = req_rect;
      push_item.store = store;
      push_item.last  = req_last;
   end

   always_comb begin
      count_in = count_ff;
      if (req_valid && push_ready) begin
         if (req_last) begin
            count_in = '0;
         end else if (store) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dnf_queue.sv
// two-entry request queue between front end and back end
// depends on dnf_pkg
`default_nettype none

module dnf_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire dnf_pkg::item_type  push_item,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output dnf_pkg::item_type       pop_item
);

   dnf_pkg::item_type entry_ff [2];
   logic              head_ff;
   logic              head_in;
   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;
   logic              do_push;
   logic              do_pop;
   logic              tail;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_item   = entry_ff[head_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign tail       = head_ff ^ cnt_ff[0];

   always_comb begin
      head_in = do_pop ? ~head_ff : head_ff;
      cnt_in  = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dnf_back.sv
// back end: rectangle store, per-row candidate scan and result register
// depends on dnf_pkg
`default_nettype none

module dnf_back #(
   parameter int MAX_RECTS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire dnf_pkg::item_type  pop_item,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output dnf_pkg::result_type     rsp_result
);

   localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CW = $clog2(MAX_RECTS + 1);

   dnf_pkg::rect_type       mem [MAX_RECTS];
   dnf_pkg::rect_type       rd_r_ff;
   dnf_pkg::rect_type       rd_c_ff;

   dnf_pkg::back_state_type state_ff;
   dnf_pkg::back_state_type state_in;

   logic [CW-1:0] wr_ff;
   logic [CW-1:0] wr_in;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] n_in;
   logic [IW-1:0] r_ff;
   logic [IW-1:0] r_in;
   logic [IW-1:0] c_ff;
   logic [IW-1:0] c_in;
   logic          p_vld_ff;
   logic          p_vld_in;
   logic [IW-1:0] p_c_ff;
   logic [IW-1:0] p_c_in;

   logic          have_ff [dnf_pkg::NUM_DIRS];
   logic          have_in [dnf_pkg::NUM_DIRS];
   logic [IW-1:0] idx_ff  [dnf_pkg::NUM_DIRS];
   logic [IW-1:0] idx_in  [dnf_pkg::NUM_DIRS];
   logic          fb_ff   [dnf_pkg::NUM_DIRS];
   logic          fb_in   [dnf_pkg::NUM_DIRS];
   logic [15:0]   bdx_ff  [dnf_pkg::NUM_DIRS];
   logic [15:0]   bdx_in  [dnf_pkg::NUM_DIRS];
   logic [15:0]   bdy_ff  [dnf_pkg::NUM_DIRS];
   logic [15:0]   bdy_in  [dnf_pkg::NUM_DIRS];

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   dnf_pkg::result_type rsp_result_ff;
   dnf_pkg::result_type rsp_result_in;

   logic          pop_go;
   logic          issue;
   logic          emit_go;
   logic          wr_en;
   logic [CW-1:0] n_m1;
   logic          c_is_last;
   logic          r_is_last;

   logic signed [16:0] xr0, xr1, yr0, yr1, xc0, xc1, yc0, yc1;
   logic signed [16:0] dx, dy;
   logic [16:0]        dx_mag, dy_mag;
   logic [15:0]        cdx, cdy;
   logic               fch, fcv, not_self;
   logic               elig   [dnf_pkg::NUM_DIRS];
   logic               fc     [dnf_pkg::NUM_DIRS];
   logic               closer [dnf_pkg::NUM_DIRS];
   logic               take   [dnf_pkg::NUM_DIRS];

   logic [IW+dnf_pkg::IDX_W-1:0] idx_ext [dnf_pkg::NUM_DIRS];
   logic [IW+dnf_pkg::IDX_W-1:0] elem_ext;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   assign n_m1      = n_ff - CW'(1);
   assign c_is_last = (CW'(c_ff) == n_m1);
   assign r_is_last = (CW'(r_ff) == n_m1);

   // control outputs
   always_comb begin
      pop_ready = (state_ff == dnf_pkg::BK_LOAD);
      issue     = (state_ff == dnf_pkg::BK_SCAN);
      emit_go   = (state_ff == dnf_pkg::BK_EMIT) && (!rsp_valid_ff || rsp_ready);
      pop_go    = pop_ready && pop_valid;
      wr_en     = pop_go && pop_item.store;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dnf_pkg::BK_LOAD: begin
            if (pop_valid && pop_item.last) begin
               state_in = dnf_pkg::BK_SCAN;
            end
         end
         dnf_pkg::BK_SCAN: begin
            if (c_is_last) begin
               state_in = dnf_pkg::BK_FLUSH;
            end
         end
         dnf_pkg::BK_FLUSH: begin
            state_in = dnf_pkg::BK_EMIT;
         end
         dnf_pkg::BK_EMIT: begin
            if (emit_go) begin
               state_in = r_is_last ? dnf_pkg::BK_LOAD : dnf_pkg::BK_SCAN;
            end
         end
         default: begin
            state_in = dnf_pkg::BK_LOAD;
         end
      endcase
   end

   // counters
   always_comb begin
      wr_in    = wr_ff;
      n_in     = n_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      p_vld_in = issue;
      p_c_in   = c_ff;
      if (pop_go) begin
         if (pop_item.last) begin
            wr_in = '0;
            n_in  = pop_item.store ? (wr_ff + CW'(1)) : wr_ff;
            r_in  = '0;
            c_in  = '0;
         end else if (pop_item.store) begin
            wr_in = wr_ff + CW'(1);
         end
      end
      if (issue) begin
         c_in = c_ff + IW'(1);
      end
      if (emit_go) begin
         c_in = '0;
         if (!r_is_last) begin
            r_in = r_ff + IW'(1);
         end
      end
   end

   // candidate geometry against the current row
   always_comb begin
      xr0 = {rd_r_ff.x[15], rd_r_ff.x};
      yr0 = {rd_r_ff.y[15], rd_r_ff.y};
      xr1 = xr0 + {2'b00, rd_r_ff.w};
      yr1 = yr0 + {2'b00, rd_r_ff.h};
      xc0 = {rd_c_ff.x[15], rd_c_ff.x};
      yc0 = {rd_c_ff.y[15], rd_c_ff.y};
      xc1 = xc0 + {2'b00, rd_c_ff.w};
      yc1 = yc0 + {2'b00, rd_c_ff.h};

      fch = ((xr0 >= xc0) && (xr0 <= xc1)) || ((xr1 >= xc0) && (xr1 <= xc1));
      fcv = ((yr0 >= yc0) && (yr0 <= yc1)) || ((yr1 >= yc0) && (yr1 <= yc1));

      dx     = xr0 - xc0;
      dy     = yr0 - yc0;
      dx_mag = dx[16] ? 17'(-dx) : 17'(dx);
      dy_mag = dy[16] ? 17'(-dy) : 17'(dy);
      cdx    = dx_mag[15:0];
      cdy    = dy_mag[15:0];

      not_self = (p_c_ff != r_ff);

      elig[dnf_pkg::DIR_UP]    = not_self && (yc1 <= yr0);
      elig[dnf_pkg::DIR_DOWN]  = not_self && (yc0 >= yr1);
      elig[dnf_pkg::DIR_LEFT]  = not_self && (xc1 <= xr0);
      elig[dnf_pkg::DIR_RIGHT] = not_self && (xc0 >= xr1);
   end

   // best-so-far update, one direction per lane
   always_comb begin
      for (int d = 0; d < dnf_pkg::NUM_DIRS; d++) begin
         if ((d == dnf_pkg::DIR_UP) || (d == dnf_pkg::DIR_DOWN)) begin
            fc[d]     = fch;
            closer[d] = (bdx_ff[d] > cdx) || ((bdx_ff[d] == cdx) && (bdy_ff[d] > cdy));
         end else begin
            fc[d]     = fcv;
            closer[d] = (bdy_ff[d] > cdy) || ((bdy_ff[d] == cdy) && (bdx_ff[d] > cdx));
         end
         take[d] = p_vld_ff && elig[d] &&
                   (!have_ff[d] || ((fb_ff[d] == fc[d]) ? closer[d] : fc[d]));

         have_in[d] = have_ff[d];
         idx_in[d]  = idx_ff[d];
         fb_in[d]   = fb_ff[d];
         bdx_in[d]  = bdx_ff[d];
         bdy_in[d]  = bdy_ff[d];
         if (take[d]) begin
            have_in[d] = 1'b1;
            idx_in[d]  = p_c_ff;
            fb_in[d]   = fc[d];
            bdx_in[d]  = cdx;
            bdy_in[d]  = cdy;
         end
         if (emit_go) begin
            have_in[d] = 1'b0;
         end
         idx_ext[d] = {{dnf_pkg::IDX_W{1'b0}}, idx_ff[d]};
      end
   end

   // result register
   always_comb begin
      elem_ext                  = {{dnf_pkg::IDX_W{1'b0}}, r_ff};
      rsp_result_in             = rsp_result_ff;
      rsp_valid_in              = rsp_valid_ff && !rsp_ready;
      if (emit_go) begin
         rsp_valid_in              = 1'b1;
         rsp_result_in.elem_index  = elem_ext[dnf_pkg::IDX_W-1:0];
         rsp_result_in.has_up      = have_ff[dnf_pkg::DIR_UP];
         rsp_result_in.up_index    = have_ff[dnf_pkg::DIR_UP] ?
                                     idx_ext[dnf_pkg::DIR_UP][dnf_pkg::IDX_W-1:0] : '0;
         rsp_result_in.has_down    = have_ff[dnf_pkg::DIR_DOWN];
         rsp_result_in.down_index  = have_ff[dnf_pkg::DIR_DOWN] ?
                                     idx_ext[dnf_pkg::DIR_DOWN][dnf_pkg::IDX_W-1:0] : '0;
         rsp_result_in.has_left    = have_ff[dnf_pkg::DIR_LEFT];
         rsp_result_in.left_index  = have_ff[dnf_pkg::DIR_LEFT] ?
                                     idx_ext[dnf_pkg::DIR_LEFT][dnf_pkg::IDX_W-1:0] : '0;
         rsp_result_in.has_right   = have_ff[dnf_pkg::DIR_RIGHT];
         rsp_result_in.right_index = have_ff[dnf_pkg::DIR_RIGHT] ?
                                     idx_ext[dnf_pkg::DIR_RIGHT][dnf_pkg::IDX_W-1:0] : '0;
         rsp_result_in.run_end     = r_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnf_pkg::BK_LOAD;
         wr_ff        <= '0;
         n_ff         <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int d = 0; d < dnf_pkg::NUM_DIRS; d++) begin
            have_ff[d] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         n_ff         <= n_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int d = 0; d < dnf_pkg::NUM_DIRS; d++) begin
            have_ff[d] <= have_in[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      p_c_ff        <= p_c_in;
      rsp_result_ff <= rsp_result_in;
      for (int d = 0; d < dnf_pkg::NUM_DIRS; d++) begin
         idx_ff[d] <= idx_in[d];
         fb_ff[d]  <= fb_in[d];
         bdx_ff[d] <= bdx_in[d];
         bdy_ff[d] <= bdy_in[d];
      end
   end

   // rectangle store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ff[IW-1:0]] <= pop_item.rect;
      end
      rd_r_ff <= mem[r_ff];
      rd_c_ff <= mem[c_ff];
   end

endmodule

`default_nettype wire

FILE: rtl/directional_neighbor_finder_unit.sv
// top level of the directional neighbor finder
// depends on dnf_pkg, dnf_front, dnf_queue, dnf_back
//
// Requests load up to MAX_RECTS rectangles in order, one per cycle while the
// two-entry request queue has room; extra rectangles are dropped. The request
// with is_last set closes the set: for each of the n stored rectangles one
// response is produced, in load order, naming the nearest rectangle wholly
// above, below, left and right of it. Each response is built by a candidate
// scan, one candidate a cycle through the two read ports of the rectangle
// store, then one pipeline flush and one transfer into the response register,
// which waits while an earlier response there is not yet accepted.
// New requests queue up behind the set being scanned and are taken once all
// of its responses have moved into the response register.
`default_nettype none

module directional_neighbor_finder_unit #(
   parameter int MAX_RECTS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_rect_x,
   input  wire logic signed [15:0] req_rect_y,
   input  wire logic [14:0]        req_rect_w,
   input  wire logic [14:0]        req_rect_h,
   input  wire logic               req_is_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [3:0]              rsp_elem_index,
   output logic                    rsp_has_up,
   output logic [3:0]              rsp_up_index,
   output logic                    rsp_has_down,
   output logic [3:0]              rsp_down_index,
   output logic                    rsp_has_left,
   output logic [3:0]              rsp_left_index,
   output logic                    rsp_has_right,
   output logic [3:0]              rsp_right_index,
   output logic                    rsp_run_end
);

   dnf_pkg::rect_type   req_rect;
   dnf_pkg::item_type   push_item;
   dnf_pkg::item_type   pop_item;
   dnf_pkg::result_type result;
   logic                push_valid;
   logic                push_ready;
   logic                pop_valid;
   logic                pop_ready;

   always_comb begin
      req_rect.x = req_rect_x;
      req_rect.y = req_rect_y;
      req_rect.w = req_rect_w;
      req_rect.h = req_rect_h;
   end

   dnf_front #(
      .MAX_RECTS (MAX_RECTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rect   (req_rect),
      .req_last   (req_is_last),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   dnf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   dnf_back #(
      .MAX_RECTS (MAX_RECTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_elem_index  = result.elem_index;
   assign rsp_has_up      = result.has_up;
   assign rsp_up_index    = result.up_index;
   assign rsp_has_down    = result.has_down;
   assign rsp_down_index  = result.down_index;
   assign rsp_has_left    = result.has_left;
   assign rsp_left_index  = result.left_index;
   assign rsp_has_right   = result.has_right;
   assign rsp_right_index = result.right_index;
   assign rsp_run_end     = result.run_end;

endmodule

`default_nettype wire

FILE: rtl/dnf_checker.sv
// port-level checks on the response channel of the neighbor finder
// depends on directional_neighbor_finder_unit; bound to it below
`default_nettype none

module dnf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_elem_index,
   input wire logic       rsp_has_up,
   input wire logic [3:0] rsp_up_index,
   input wire logic       rsp_has_down,
   input wire logic [3:0] rsp_down_index,
   input wire logic       rsp_has_left,
   input wire logic [3:0] rsp_left_index,
   input wire logic       rsp_has_right,
   input wire logic [3:0] rsp_right_index,
   input wire logic       rsp_run_end
);

   logic [3:0] expect_idx_ff;
   logic [3:0] expect_idx_in;

   always_comb begin
      expect_idx_in = expect_idx_ff;
      if (rsp_valid && rsp_ready) begin
         expect_idx_in = rsp_run_end ? 4'd0 : (rsp_elem_index + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_idx_ff <= 4'd0;
      end else begin
         expect_idx_ff <= expect_idx_in;
      end
   end

   // responses of a set come in load order starting at zero
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_elem_index == expect_idx_ff))
      else $error("response out of load order");

   // no neighbor means index zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_has_up || rsp_up_index == 4'd0) &&
                     (rsp_has_down || rsp_down_index == 4'd0) &&
                     (rsp_has_left || rsp_left_index == 4'd0) &&
                     (rsp_has_right || rsp_right_index == 4'd0)))
      else $error("index set without neighbor");

   // stalled response stays valid and keeps its element index, up index and run end
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_elem_index) &&
                                     $stable(rsp_run_end) && $stable(rsp_up_index)))
      else $error("stalled response changed");

   // no response right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind directional_neighbor_finder_unit dnf_checker u_dnf_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_elem_index  (rsp_elem_index),
   .rsp_has_up      (rsp_has_up),
   .rsp_up_index    (rsp_up_index),
   .rsp_has_down    (rsp_has_down),
   .rsp_down_index  (rsp_down_index),
   .rsp_has_left    (rsp_has_left),
   .rsp_left_index  (rsp_left_index),
   .rsp_has_right   (rsp_has_right),
   .rsp_right_index (rsp_right_index),
   .rsp_run_end     (rsp_run_end)
);

`default_nettype wire
